// File: src/rdsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the row dark segment finder.
// Used by every module of the block; depends on nothing.
package rdsf_pkg;

   typedef struct packed {
      logic [15:0]        pixel;
      logic [9:0]         xpos;
      logic               first;
      logic               last;
      logic               mode;
      logic signed [11:0] reference;
      logic [10:0]        min_run;
      logic [10:0]        max_run;
      logic [10:0]        overlap;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [9:0] seg_start;
      logic [9:0] seg_end;
      logic [9:0] seg_center;
      logic [10:0] seg_width;
      logic [7:0] seg_luma;
   } rsp_type;

   typedef struct packed {
      logic [7:0] luma_threshold;
      logic       sat_guard_en;
      logic [7:0] saturation_limit;
      logic       bridge_enable;
   } cfg_type;

   // An accepted run that the back end still has to rank.
   typedef struct packed {
      logic        valid;
      logic [9:0]  s;
      logic [9:0]  e;
      logic [9:0]  c;
      logic [10:0] w;
      logic [11:0] key;
   } close_type;

   typedef struct packed {
      logic [9:0] wr_x;
      logic [7:0] wr_lum;
      logic       clear;
      logic       emit;
      close_type  close_a;
      close_type  close_b;
   } entry_type;

   localparam logic [1:0] CSR_LUMA_THRESHOLD   = 2'd0;
   localparam logic [1:0] CSR_SATURATION_GUARD = 2'd1;
   localparam logic [1:0] CSR_SATURATION_LIMIT = 2'd2;
   localparam logic [1:0] CSR_BRIDGE_ENABLE    = 2'd3;

   localparam logic [7:0] RESET_LUMA_THRESHOLD   = 8'd64;
   localparam logic       RESET_SATURATION_GUARD = 1'b0;
   localparam logic [7:0] RESET_SATURATION_LIMIT = 8'd255;
   localparam logic       RESET_BRIDGE_ENABLE    = 1'b1;

   // v*255/31 is v*255*8457 >> 18, and v*255/63 is v*255*16645 >> 20.
   localparam logic [21:0] EXP5_MUL = 22'd2156535;
   localparam logic [22:0] EXP6_MUL = 23'd4244475;

   localparam logic [7:0] LUMA_R = 8'd77;
   localparam logic [7:0] LUMA_G = 8'd150;
   localparam logic [7:0] LUMA_B = 8'd29;

   // n/3 for n below 768 is n*683 >> 11.
   localparam logic [9:0] DIV3_MUL = 10'd683;

   // In widest mode the rank key is this base minus the width.
   localparam logic [11:0] KEY_WIDE_BASE = 12'd1024;

   localparam int QUEUE_DEPTH = 4;

endpackage

// File: src/rdsf_front.sv
`timescale 1ns / 1ps
// Front end: pixel expansion, luma and saturation, darkness, bridging and run tracking.
// Pushes one queue entry per pixel; depends on rdsf_pkg.
module rdsf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rdsf_pkg::req_type    req_data,
   input  rdsf_pkg::cfg_type    cfg,
   input  logic                 q_full,
   output logic                 q_push,
   output rdsf_pkg::entry_type  q_entry
);

   logic                 front_en;
   logic [26:0]          r_prod, b_prod;
   logic [28:0]          g_prod;
   logic                 a1_valid_ff;
   rdsf_pkg::req_type    a1_req_ff;
   logic [7:0]           a1_r_ff, a1_g_ff, a1_b_ff;
   logic [15:0]          luma_sum;
   logic [7:0]           hi, lo, lum;
   logic                 raw;
   logic                 a2_valid_ff;
   rdsf_pkg::req_type    a2_req_ff;
   logic [7:0]           a2_lum_ff;
   logic                 a2_raw_ff;

   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_first_ff, pend_first_in;
   logic [1:0]           pend_dark_ff, pend_dark_in;
   logic [9:0]           pend_x_ff, pend_x_in;
   logic                 inside_ff, inside_in;
   logic [9:0]           open_col_ff, open_col_in;
   logic [9:0]           last_col_ff, last_col_in;
   logic                 set_mode_ff, set_mode_in;
   logic signed [11:0]   set_ref_ff, set_ref_in;
   logic [10:0]          set_min_ff, set_min_in;
   logic [10:0]          set_max_ff, set_max_in;
   logic [10:0]          set_ovl_ff, set_ovl_in;

   logic                 pv0, ins0, ins1, dark_a, fire_a, fire_b;
   logic [9:0]           start1, lc1, s_b, e_b;

   function automatic rdsf_pkg::close_type eval_close(
      input logic               fire,
      input logic [9:0]         s,
      input logic [9:0]         e,
      input logic               mode,
      input logic signed [11:0] ref_col,
      input logic [10:0]        min_w,
      input logic [10:0]        max_w,
      input logic [10:0]        ovl
   );
      logic signed [12:0] w;
      logic [10:0]        sum;
      logic [9:0]         c;
      logic signed [12:0] d;
      logic [11:0]        gap;
      logic signed [13:0] hi_lim, lo_lim;
      logic               width_ok, touch_ok;
      rdsf_pkg::close_type res;
      w = $signed({3'b0, e}) - $signed({3'b0, s}) + 13'sd1;
      width_ok = (w >= $signed({2'b0, min_w})) && (w <= $signed({2'b0, max_w}));
      sum = {1'b0, s} + {1'b0, e};
      c = sum[10:1];
      d = $signed({3'b0, c}) - $signed({ref_col[11], ref_col});
      gap = d[12] ? 12'(-d) : 12'(d);
      hi_lim = $signed({{2{ref_col[11]}}, ref_col}) + $signed({3'b0, ovl});
      lo_lim = $signed({{2{ref_col[11]}}, ref_col}) - $signed({3'b0, ovl});
      touch_ok = ($signed({4'b0, s}) <= hi_lim) && ($signed({4'b0, e}) >= lo_lim);
      res.valid = fire && width_ok && (!mode || touch_ok);
      res.s = s;
      res.e = e;
      res.c = c;
      res.w = w[10:0];
      res.key = mode ? (rdsf_pkg::KEY_WIDE_BASE - {1'b0, w[10:0]}) : gap;
      return res;
   endfunction

   assign front_en  = !(a2_valid_ff && q_full);
   assign req_stall = !front_en;
   assign q_push    = a2_valid_ff && !q_full;

   // Stage one: widen the 565 channels to eight bits.
   assign r_prod = 27'(req_data.pixel[15:11]) * 27'(rdsf_pkg::EXP5_MUL);
   assign g_prod = 29'(req_data.pixel[10:5]) * 29'(rdsf_pkg::EXP6_MUL);
   assign b_prod = 27'(req_data.pixel[4:0]) * 27'(rdsf_pkg::EXP5_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff <= 1'b0;
      end else if (front_en) begin
         a1_valid_ff <= req_valid;
      end
      if (front_en) begin
         a1_req_ff <= req_data;
         a1_r_ff   <= r_prod[25:18];
         a1_g_ff   <= g_prod[27:20];
         a1_b_ff   <= b_prod[25:18];
      end
   end

   // Stage two: luma, saturation and the raw dark decision.
   always_comb begin
      luma_sum = 16'(a1_r_ff) * 16'(rdsf_pkg::LUMA_R) + 16'(a1_g_ff) * 16'(rdsf_pkg::LUMA_G)
               + 16'(a1_b_ff) * 16'(rdsf_pkg::LUMA_B);
      lum = luma_sum[15:8];
      hi = (a1_r_ff > a1_g_ff) ? a1_r_ff : a1_g_ff;
      lo = (a1_r_ff < a1_g_ff) ? a1_r_ff : a1_g_ff;
      if (a1_b_ff > hi) begin
         hi = a1_b_ff;
      end
      if (a1_b_ff < lo) begin
         lo = a1_b_ff;
      end
      raw = (lum <= cfg.luma_threshold)
         && (!cfg.sat_guard_en || ((hi - lo) <= cfg.saturation_limit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_valid_ff <= 1'b0;
      end else if (front_en) begin
         a2_valid_ff <= a1_valid_ff;
      end
      if (front_en) begin
         a2_req_ff <= a1_req_ff;
         a2_lum_ff <= lum;
         a2_raw_ff <= raw;
      end
   end

   // Stage three: the pending pixel is resolved once its right neighbor is known.
   always_comb begin
      if (a2_req_ff.first) begin
         set_mode_in = a2_req_ff.mode;
         set_ref_in  = a2_req_ff.reference;
         set_min_in  = a2_req_ff.min_run;
         set_max_in  = a2_req_ff.max_run;
         set_ovl_in  = a2_req_ff.overlap;
      end else begin
         set_mode_in = set_mode_ff;
         set_ref_in  = set_ref_ff;
         set_min_in  = set_min_ff;
         set_max_in  = set_max_ff;
         set_ovl_in  = set_ovl_ff;
      end
      pv0  = pend_valid_ff && !a2_req_ff.first;
      ins0 = inside_ff && !a2_req_ff.first;
      dark_a = pend_dark_ff[0]
            || (cfg.bridge_enable && !pend_first_ff && pend_dark_ff[1] && a2_raw_ff);
      fire_a = 1'b0;
      ins1   = ins0;
      start1 = open_col_ff;
      lc1    = last_col_ff;
      if (pv0) begin
         if (dark_a) begin
            ins1   = 1'b1;
            start1 = ins0 ? open_col_ff : pend_x_ff;
            lc1    = pend_x_ff;
         end else begin
            fire_a = ins0;
            ins1   = 1'b0;
         end
      end
      fire_b = a2_req_ff.last && (a2_raw_ff || ins1);
      s_b = a2_raw_ff ? (ins1 ? start1 : a2_req_ff.xpos) : start1;
      e_b = a2_raw_ff ? a2_req_ff.xpos : lc1;

      q_entry.wr_x    = a2_req_ff.xpos;
      q_entry.wr_lum  = a2_lum_ff;
      q_entry.clear   = a2_req_ff.first;
      q_entry.emit    = a2_req_ff.last;
      q_entry.close_a = eval_close(fire_a, open_col_ff, last_col_ff, set_mode_in,
                                   set_ref_in, set_min_in, set_max_in, set_ovl_in);
      q_entry.close_b = eval_close(fire_b, s_b, e_b, set_mode_in,
                                   set_ref_in, set_min_in, set_max_in, set_ovl_in);

      if (a2_req_ff.last) begin
         pend_valid_in = 1'b0;
         pend_dark_in  = 2'b00;
         inside_in     = 1'b0;
         open_col_in   = s_b;
         last_col_in   = e_b;
         pend_first_in = pend_first_ff;
         pend_x_in     = pend_x_ff;
      end else begin
         pend_valid_in = 1'b1;
         pend_dark_in  = {pv0 && pend_dark_ff[0], a2_raw_ff};
         inside_in     = ins1;
         open_col_in   = start1;
         last_col_in   = lc1;
         pend_first_in = !pv0;
         pend_x_in     = a2_req_ff.xpos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_first_ff <= 1'b0;
         pend_dark_ff  <= 2'b00;
         pend_x_ff     <= '0;
         inside_ff     <= 1'b0;
         open_col_ff   <= '0;
         last_col_ff   <= '0;
         set_mode_ff   <= 1'b0;
         set_ref_ff    <= '0;
         set_min_ff    <= '0;
         set_max_ff    <= '0;
         set_ovl_ff    <= '0;
      end else if (q_push) begin
         pend_valid_ff <= pend_valid_in;
         pend_first_ff <= pend_first_in;
         pend_dark_ff  <= pend_dark_in;
         pend_x_ff     <= pend_x_in;
         inside_ff     <= inside_in;
         open_col_ff   <= open_col_in;
         last_col_ff   <= last_col_in;
         set_mode_ff   <= set_mode_in;
         set_ref_ff    <= set_ref_in;
         set_min_ff    <= set_min_in;
         set_max_ff    <= set_max_in;
         set_ovl_ff    <= set_ovl_in;
      end
   end

endmodule

// File: src/rdsf_queue.sv
`timescale 1ns / 1ps
// Short FIFO of front-end entries that decouples the front and back ends.
// Depends on rdsf_pkg for the entry type and depth.
module rdsf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rdsf_pkg::entry_type  entry_in,
   input  logic                 pop,
   output rdsf_pkg::entry_type  head,
   output logic                 full,
   output logic                 empty
);

   localparam int PW = $clog2(rdsf_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(rdsf_pkg::QUEUE_DEPTH + 1);

   rdsf_pkg::entry_type slots_ff [rdsf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign head  = slots_ff[rd_ptr_ff];
   assign full  = (count_ff == CW'(rdsf_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(rdsf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(rdsf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(rdsf_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// File: src/rdsf_back.sv
`timescale 1ns / 1ps
// Back end: luma row store, run luma averaging, best-run ranking and the result register.
// Consumes queue entries in order; depends on rdsf_pkg.
module rdsf_back #(
   parameter int ROW_PIXELS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  rdsf_pkg::entry_type  q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rdsf_pkg::rsp_type    rsp_data
);

   localparam int AW = $clog2(ROW_PIXELS);
   localparam int MOD_SHIFT = 22;
   localparam logic [31:0] MOD_MUL = 32'((2 ** MOD_SHIFT + ROW_PIXELS - 1) / ROW_PIXELS);

   typedef struct packed {
      logic                wr_en;
      logic [9:0]          wr_x;
      logic [7:0]          wr_lum;
      rdsf_pkg::close_type close;
      logic                clear;
      logic                emit;
   } op_type;

   logic                en, two, take, phase_ff, phase_in;
   rdsf_pkg::close_type sel;
   op_type              op_in;

   logic                p1_valid_ff;
   op_type              p1_op_ff;
   logic [9:0]          p1_qs_ff, p1_qe_ff, p1_qc_ff, p1_qw_ff;
   logic [AW-1:0]       addr_s, addr_e, addr_c, addr_w;
   logic                wr_fire;

   logic [7:0]          store_a [ROW_PIXELS];
   logic [7:0]          store_b [ROW_PIXELS];
   logic [7:0]          rd_s_ff, rd_e_ff, rd_c_ff;
   logic                p2_valid_ff;
   rdsf_pkg::close_type p2_close_ff;
   logic                p2_clear_ff, p2_emit_ff;
   logic [2:0]          p2_byp_ff;
   logic [7:0]          p2_lum_ff;
   logic [7:0]          ls, le, lc;
   logic [9:0]          lsum;
   logic [19:0]         lprod;

   logic                p3_valid_ff;
   rdsf_pkg::close_type p3_close_ff;
   logic                p3_clear_ff, p3_emit_ff;
   logic [7:0]          p3_lum_ff;

   logic                bv, better;
   logic                best_valid_ff, best_valid_in;
   logic [11:0]         best_key_ff;
   logic [7:0]          best_lum_ff;
   logic [9:0]          best_start_ff, best_end_ff, best_center_ff;
   logic [10:0]         best_width_ff;
   logic                rsp_valid_ff;
   rdsf_pkg::rsp_type   rsp_data_ff, rsp_in;

   function automatic logic [9:0] mod_quot(input logic [9:0] v);
      logic [31:0] p;
      p = 32'(v) * MOD_MUL;
      return p[31:22];
   endfunction

   function automatic logic [AW-1:0] mod_rest(input logic [9:0] v, input logic [9:0] q);
      logic [22:0] diff;
      diff = 23'(v) - 23'(q) * 23'(ROW_PIXELS);
      return diff[AW-1:0];
   endfunction

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Issue: an entry with two closed runs issues close_a first, then close_b, and is popped with close_b.
   always_comb begin
      two  = q_entry.close_a.valid && q_entry.close_b.valid;
      take = !q_empty;
      sel  = (phase_ff || !q_entry.close_a.valid) ? q_entry.close_b : q_entry.close_a;
      q_pop = en && take && (!two || phase_ff);
      phase_in = (en && take && two) ? !phase_ff : phase_ff;
      op_in.wr_en  = !phase_ff;
      op_in.wr_x   = q_entry.wr_x;
      op_in.wr_lum = q_entry.wr_lum;
      op_in.close  = sel;
      op_in.clear  = q_entry.clear && !phase_ff;
      op_in.emit   = q_entry.emit && (!two || phase_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         phase_ff    <= phase_in;
         p1_valid_ff <= take;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_op_ff <= op_in;
         p1_qs_ff <= mod_quot(sel.s);
         p1_qe_ff <= mod_quot(sel.e);
         p1_qc_ff <= mod_quot(sel.c);
         p1_qw_ff <= mod_quot(q_entry.wr_x);
      end
   end

   // Store access: the pixel's own write and the three reads of a run happen together.
   assign addr_s  = mod_rest(p1_op_ff.close.s, p1_qs_ff);
   assign addr_e  = mod_rest(p1_op_ff.close.e, p1_qe_ff);
   assign addr_c  = mod_rest(p1_op_ff.close.c, p1_qc_ff);
   assign addr_w  = mod_rest(p1_op_ff.wr_x, p1_qw_ff);
   assign wr_fire = en && p1_valid_ff && p1_op_ff.wr_en;

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         store_a[addr_w] <= p1_op_ff.wr_lum;
      end
      if (en) begin
         rd_s_ff <= store_a[addr_s];
         rd_e_ff <= store_a[addr_e];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         store_b[addr_w] <= p1_op_ff.wr_lum;
      end
      if (en) begin
         rd_c_ff <= store_b[addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_close_ff <= p1_op_ff.close;
         p2_clear_ff <= p1_op_ff.clear;
         p2_emit_ff  <= p1_op_ff.emit;
         p2_lum_ff   <= p1_op_ff.wr_lum;
         p2_byp_ff   <= {p1_op_ff.wr_en && (addr_c == addr_w),
                         p1_op_ff.wr_en && (addr_e == addr_w),
                         p1_op_ff.wr_en && (addr_s == addr_w)};
      end
   end

   // A read of the column written in the same cycle takes the new luma.
   always_comb begin
      ls = p2_byp_ff[0] ? p2_lum_ff : rd_s_ff;
      le = p2_byp_ff[1] ? p2_lum_ff : rd_e_ff;
      lc = p2_byp_ff[2] ? p2_lum_ff : rd_c_ff;
      lsum  = 10'(ls) + 10'(le) + 10'(lc);
      lprod = 20'(lsum) * 20'(rdsf_pkg::DIV3_MUL);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_close_ff <= p2_close_ff;
         p3_clear_ff <= p2_clear_ff;
         p3_emit_ff  <= p2_emit_ff;
         p3_lum_ff   <= lprod[18:11];
      end
   end

   // Ranking: a smaller key wins, then a darker run; an earlier run keeps a full tie.
   always_comb begin
      bv = best_valid_ff && !p3_clear_ff;
      better = p3_close_ff.valid && (!bv || (p3_close_ff.key < best_key_ff)
            || ((p3_close_ff.key == best_key_ff) && (p3_lum_ff < best_lum_ff)));
      best_valid_in = (bv || better) && !p3_emit_ff;
      rsp_in.found      = bv || better;
      rsp_in.seg_start  = better ? p3_close_ff.s : best_start_ff;
      rsp_in.seg_end    = better ? p3_close_ff.e : best_end_ff;
      rsp_in.seg_center = better ? p3_close_ff.c : best_center_ff;
      rsp_in.seg_width  = better ? p3_close_ff.w : best_width_ff;
      rsp_in.seg_luma   = better ? p3_lum_ff : best_lum_ff;
      if (!(bv || better)) begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else if (en && p3_valid_ff) begin
         best_valid_ff <= best_valid_in;
      end
      if (en && p3_valid_ff && better) begin
         best_key_ff    <= p3_close_ff.key;
         best_lum_ff    <= p3_lum_ff;
         best_start_ff  <= p3_close_ff.s;
         best_end_ff    <= p3_close_ff.e;
         best_center_ff <= p3_close_ff.c;
         best_width_ff  <= p3_close_ff.w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p3_valid_ff && p3_emit_ff;
      end
      if (en && p3_valid_ff && p3_emit_ff) begin
         rsp_data_ff <= rsp_in;
      end
   end

   a_phase_needs_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!q_empty && q_entry.close_a.valid && q_entry.close_b.valid))
      else $error("second issue cycle without a two-run entry at the head");
   a_emit_gives_result: assert property (@(posedge clock) disable iff (reset)
      (en && p3_valid_ff && p3_emit_ff) |=> rsp_valid_ff)
      else $error("row end did not load the result register");

endmodule

// File: src/row_dark_segment_finder.sv
`timescale 1ns / 1ps
// Row dark segment finder: finds the best dark run in a row of RGB565 pixels.
// Top level with the register port; depends on rdsf_pkg, rdsf_front, rdsf_queue, rdsf_back.
//
// Usage: pixels of a row enter on the req_ channel, one beat per pixel in
// scan order; first marks the row's first pixel and carries the row fields,
// last marks its final pixel. For every beat with last set the rsp_ channel
// delivers one beat: the best run, or found low with all fields zero.
// Throughput is one pixel per cycle while req_stall is low. A row end that
// closes two runs at once holds the issue stage of the back end while it
// issues both runs; the queue absorbs it. The three-stage pixel path feeds a
// four-entry queue; the back end reads the luma store through two copies, so
// one run is ranked per cycle unless the result is stalled. When the receiver
// stalls, the result holds and the back end waits; pixels are still taken
// until the queue fills, then req_stall rises. Reset clears control state and
// restores register defaults; the luma store is not cleared and needs no
// clearing pass. Registers are to be written only idle by the user; the block
// does not enforce it.
module row_dark_segment_finder #(
   parameter int ROW_PIXELS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rdsf_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rdsf_pkg::rsp_type  rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   rdsf_pkg::cfg_type   cfg_ff;
   rdsf_pkg::entry_type push_entry, head_entry;
   logic                q_push, q_pop, q_full, q_empty, wr_fire;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.luma_threshold   <= rdsf_pkg::RESET_LUMA_THRESHOLD;
         cfg_ff.sat_guard_en     <= rdsf_pkg::RESET_SATURATION_GUARD;
         cfg_ff.saturation_limit <= rdsf_pkg::RESET_SATURATION_LIMIT;
         cfg_ff.bridge_enable    <= rdsf_pkg::RESET_BRIDGE_ENABLE;
      end else if (wr_fire) begin
         case (paddr[3:2])
            rdsf_pkg::CSR_LUMA_THRESHOLD:   cfg_ff.luma_threshold   <= pwdata[7:0];
            rdsf_pkg::CSR_SATURATION_GUARD: cfg_ff.sat_guard_en     <= pwdata[0];
            rdsf_pkg::CSR_SATURATION_LIMIT: cfg_ff.saturation_limit <= pwdata[7:0];
            rdsf_pkg::CSR_BRIDGE_ENABLE:    cfg_ff.bridge_enable    <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         rdsf_pkg::CSR_LUMA_THRESHOLD:   prdata = {24'b0, cfg_ff.luma_threshold};
         rdsf_pkg::CSR_SATURATION_GUARD: prdata = {31'b0, cfg_ff.sat_guard_en};
         rdsf_pkg::CSR_SATURATION_LIMIT: prdata = {24'b0, cfg_ff.saturation_limit};
         rdsf_pkg::CSR_BRIDGE_ENABLE:    prdata = {31'b0, cfg_ff.bridge_enable};
         default:                        prdata = '0;
      endcase
   end

   rdsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   rdsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (push_entry),
      .pop      (q_pop),
      .head     (head_entry),
      .full     (q_full),
      .empty    (q_empty)
   );

   rdsf_back #(
      .ROW_PIXELS (ROW_PIXELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (head_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of row_dark_segment_finder: random rows of RGB565 pixels
// are predicted pixel by pixel and every row result is compared field by field.
// Depends on rdsf_pkg and row_dark_segment_finder.
module testbench;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   rdsf_pkg::req_type   req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rdsf_pkg::rsp_type   rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [3:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   row_dark_segment_finder DUT (.*);

   always #5 clock = ~clock;

   rdsf_pkg::req_type pixel_q[$];
   rdsf_pkg::rsp_type segment_q[$];
   int      errors = 0;
   int      rows_done = 0;
   int      rows_found = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   bit      last_phase = 0;

   // Predictor state: registers, luma store, run tracking and the row latch.
   int      thr = 64, sat_guard = 0, sat_limit = 255, bridge = 1;
   int      luma_mem[1024];
   bit [1:0] pend_dark;
   bit      pend_valid, pend_first, in_run, best_valid;
   int      pend_x, open_col, last_col;
   int      best_s, best_e, best_c, best_w, best_l;
   int      row_mode, row_ref, row_minw, row_maxw, row_ovl;

   // The closing stretch of the run goes without idle cycles.
   function automatic bit quiet();
      return last_phase && pixel_q.size() < 120;
   endfunction

   function void clear_best();
      best_valid = 0;
      best_s = 0; best_e = 0; best_c = 0; best_w = 0; best_l = 0;
   endfunction

   function void close_run();
      int s, e, w, c, lm, d, bd;
      bit better;
      s = open_col;
      e = last_col;
      w = e - s + 1;
      in_run = 0;
      if (w < row_minw || w > row_maxw) return;
      c = (s + e) / 2;
      lm = (luma_mem[s % 1024] + luma_mem[c % 1024] + luma_mem[e % 1024]) / 3;
      if (row_mode == 0) begin
         d = c - row_ref;
         bd = best_c - row_ref;
         if (d < 0) d = -d;
         if (bd < 0) bd = -bd;
         better = !best_valid || d < bd || (d == bd && lm < best_l);
      end else begin
         if (!(s <= row_ref + row_ovl && e >= row_ref - row_ovl)) return;
         better = !best_valid || w > best_w || (w == best_w && lm < best_l);
      end
      if (better) begin
         best_s = s; best_e = e; best_c = c; best_w = w; best_l = lm;
         best_valid = 1;
      end
   endfunction

   function void feed_pixel(bit dark, int x);
      if (dark) begin
         if (!in_run) begin
            in_run = 1;
            open_col = x;
         end
         last_col = x;
      end else if (in_run) begin
         close_run();
      end
   endfunction

   function void predict_pixel(rdsf_pkg::req_type t);
      int r, g, b, lum, hi, lo, x;
      bit raw, d;
      rdsf_pkg::rsp_type res;
      r = int'(t.pixel[15:11]) * 255 / 31;
      g = int'(t.pixel[10:5]) * 255 / 63;
      b = int'(t.pixel[4:0]) * 255 / 31;
      lum = ((77 * r + 150 * g + 29 * b) >> 8) & 255;
      hi = (r > g) ? r : g;
      lo = (r < g) ? r : g;
      if (b > hi) hi = b;
      if (b < lo) lo = b;
      raw = lum <= thr && (sat_guard == 0 || hi - lo <= sat_limit);
      x = int'(t.xpos);
      luma_mem[x] = lum;
      if (t.first) begin
         row_mode = int'(t.mode);
         row_ref = int'(t.reference[11:0]) - (t.reference[11] ? 4096 : 0);
         row_minw = int'(t.min_run);
         row_maxw = int'(t.max_run);
         row_ovl = int'(t.overlap);
         in_run = 0;
         clear_best();
         pend_valid = 0;
         pend_dark = 0;
      end
      if (pend_valid) begin
         d = pend_dark[0] || (bridge != 0 && !pend_first && pend_dark[1] && raw);
         feed_pixel(d, pend_x);
      end
      if (t.last) begin
         feed_pixel(raw, x);
         if (in_run) close_run();
         pend_valid = 0;
         pend_dark = 0;
         res.found = best_valid;
         res.seg_start = best_s[9:0];
         res.seg_end = best_e[9:0];
         res.seg_center = best_c[9:0];
         res.seg_width = best_w[10:0];
         res.seg_luma = best_l[7:0];
         segment_q.push_back(res);
         in_run = 0;
         clear_best();
         return;
      end
      pend_dark = {pend_valid ? pend_dark[0] : 1'b0, raw};
      pend_first = t.first || !pend_valid;
      pend_x = x;
      pend_valid = 1;
   endfunction

   task automatic report(string field, int got, int want);
      errors++;
      $display("row result %0d: %s is %0d, predicted %0d", rows_done, field, got, want);
   endtask

   // Driver: a new beat is presented only once the previous one was taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid && !quiet() && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 10);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixel_q.size() > 0) begin
            req_data <= pixel_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet() && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predicts on accepted pixel beats and checks accepted result beats.
   always @(posedge clock) begin
      rdsf_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_pixel(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (segment_q.size() == 0) begin
               report("unexpected beat", 1, 0);
            end else begin
               want = segment_q.pop_front();
               if (rsp_data.found !== want.found)
                  report("found", int'(rsp_data.found), int'(want.found));
               if (rsp_data.seg_start !== want.seg_start)
                  report("seg_start", int'(rsp_data.seg_start), int'(want.seg_start));
               if (rsp_data.seg_end !== want.seg_end)
                  report("seg_end", int'(rsp_data.seg_end), int'(want.seg_end));
               if (rsp_data.seg_center !== want.seg_center)
                  report("seg_center", int'(rsp_data.seg_center), int'(want.seg_center));
               if (rsp_data.seg_width !== want.seg_width)
                  report("seg_width", int'(rsp_data.seg_width), int'(want.seg_width));
               if (rsp_data.seg_luma !== want.seg_luma)
                  report("seg_luma", int'(rsp_data.seg_luma), int'(want.seg_luma));
               if (want.found) rows_found++;
            end
            rows_done++;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, int val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         rdsf_pkg::CSR_LUMA_THRESHOLD:   thr = val & 255;
         rdsf_pkg::CSR_SATURATION_GUARD: sat_guard = val & 1;
         rdsf_pkg::CSR_SATURATION_LIMIT: sat_limit = val & 255;
         rdsf_pkg::CSR_BRIDGE_ENABLE:    bridge = val & 1;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pixel_q.size() != 0 || req_valid || segment_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic push_pixel(logic [15:0] px, int x, bit f, bit l, bit md, int rf,
                             int mn, int mx, int ov);
      rdsf_pkg::req_type t;
      t.pixel = px;
      t.xpos = x[9:0];
      t.first = f;
      t.last = l;
      t.mode = md;
      t.reference = rf[11:0];
      t.min_run = mn[10:0];
      t.max_run = mx[10:0];
      t.overlap = ov[10:0];
      pixel_q.push_back(t);
   endtask

   function automatic logic [15:0] dark_pixel();
      if ($urandom_range(0, 3) == 0) return 16'h0000;
      return {5'($urandom_range(0, 7)), 6'($urandom_range(0, 14)), 5'($urandom_range(0, 7))};
   endfunction

   // One row window: alternating dark and light stretches, so that single
   // light pixels inside a dark run exercise the bridging.
   task automatic queue_row(int len, int noise);
      int x0, seg, rf, mn, mx, ov;
      bit dark, md;
      x0 = $urandom_range(0, 1023);
      md = $urandom_range(0, 1);
      rf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) - 1024
                                       : x0 + $urandom_range(0, len + 10) - 5;
      mn = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 4);
      mx = ($urandom_range(0, 9) == 0) ? 1024 : mn + $urandom_range(0, 10);
      ov = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 10);
      dark = $urandom_range(0, 1);
      seg = 0;
      for (int i = 0; i < len; i++) begin
         if (seg == 0) begin
            dark = !dark;
            seg = dark ? $urandom_range(1, 8) : $urandom_range(1, 3);
         end
         seg--;
         push_pixel(dark ? dark_pixel() : 16'($urandom),
                    (noise == 2) ? $urandom_range(0, 1023) : (x0 + i) % 1024,
                    (noise != 3 && i == 0) || (noise == 1 && i == len / 2),
                    i == len - 1, md, rf, mn, mx, ov);
      end
   endtask

   task automatic run_phase(int items);
      int n, len, noise;
      n = 0;
      while (n < items) begin
         len = $urandom_range(1, 40);
         noise = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
         queue_row(len, noise);
         n += len;
      end
   endtask

   initial begin
      clear_best();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Pixels before any window start run with the all-zero row latch.
      push_pixel(16'h0000, 5, 0, 0, 0, 5, 1, 1024, 0);
      push_pixel(16'h0000, 6, 0, 1, 0, 5, 1, 1024, 0);
      // A full row then fills every luma store entry.
      for (int i = 0; i < 1024; i++)
         push_pixel((i % 97 < 60) ? 16'h0000 : 16'hFFFF, i, i == 0, i == 1023,
                    i[0], 2047, 1, 1024, 1024);
      push_pixel(16'h0000, 0, 1, 1, 0, -1024, 1, 1, 0);
      push_pixel(16'hFFFF, 1023, 1, 1, 1, 2047, 1, 1024, 1024);
      for (int i = 0; i < 8; i++)
         push_pixel((i == 3) ? 16'hFFFF : 16'h0000, 1020 + i, i == 0, i == 7,
                    1, 1023, 1, 1024, 0);
      for (int i = 0; i < 6; i++)
         push_pixel((i == 2 || i == 4) ? 16'hF800 : 16'h0841, 100 + i, i == 0, i == 5,
                    0, -1, 1, 2, 0);
      run_phase(120);
      wait_idle();

      csr_write(rdsf_pkg::CSR_LUMA_THRESHOLD, 255);
      csr_write(rdsf_pkg::CSR_SATURATION_GUARD, 1);
      csr_write(rdsf_pkg::CSR_SATURATION_LIMIT, 0);
      csr_write(rdsf_pkg::CSR_BRIDGE_ENABLE, 0);
      run_phase(120);
      wait_idle();

      csr_write(rdsf_pkg::CSR_LUMA_THRESHOLD, 0);
      csr_write(rdsf_pkg::CSR_SATURATION_GUARD, 0);
      csr_write(rdsf_pkg::CSR_SATURATION_LIMIT, 255);
      csr_write(rdsf_pkg::CSR_BRIDGE_ENABLE, 1);
      run_phase(120);
      wait_idle();

      csr_write(rdsf_pkg::CSR_LUMA_THRESHOLD, $urandom_range(20, 120));
      csr_write(rdsf_pkg::CSR_SATURATION_GUARD, 1);
      csr_write(rdsf_pkg::CSR_SATURATION_LIMIT, $urandom_range(10, 120));
      last_phase = 1;
      run_phase(200);
      wait_idle();
      repeat (20) @(posedge clock);

      $display("Checked %0d row results, %0d with a run found, over four register settings.",
               rows_done, rows_found);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("Run timed out with %0d results still pending.", segment_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
src/rdsf_pkg.sv
src/rdsf_front.sv
src/rdsf_queue.sv
src/rdsf_back.sv
src/row_dark_segment_finder.sv
test/testbench.sv
